### src/cwc_pkg.sv
// cwc_pkg: shared types and constants for the congestion window controller
// event opcodes, register indexes, reset values and the result/config structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cwc_pkg;

  localparam int MAX_WINDOW_DEF = 255;
  localparam int DUP_LIMIT_DEF  = 3;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0]  INIT_WINDOW_RST   = 8'd1;
  localparam logic [7:0]  INIT_SSTHRESH_RST = 8'd64;
  localparam logic [15:0] RTT_TICKS_RST     = 16'd10;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd30;

  typedef enum logic [1:0] {
    OP_ACK   = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_INIT_WINDOW   = 2'd0,
    REG_INIT_SSTHRESH = 2'd1,
    REG_RTT_TICKS     = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  init_window;
    logic [7:0]  init_ssthresh;
    logic [15:0] rtt_ticks;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  window_now;
    logic [7:0]  threshold_now;
    logic        avoid_mode;
    logic        fast_resend;
    logic [31:0] resend_seq;
    logic        timeout_resend;
    logic        session_active;
  } result_t;

  typedef struct packed {
    logic       active;
    logic [7:0] cwnd;
  } status_t;

endpackage

`default_nettype wire

### src/cwc_engine.sv
// cwc_engine: congestion window state and its per-transaction update
// holds window, threshold, mode, ack history and both tick timers
// depends on cwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cwc_engine import cwc_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int DUP_LIMIT  = DUP_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] ack_number,
  input  wire cfg_t        cfg,
  output result_t          result,
  output status_t          stat
);

  localparam logic [7:0] MAX_W = 8'(MAX_WINDOW);
  localparam logic [1:0] DUP_L = 2'(DUP_LIMIT);

  logic        active, active_next;
  logic [7:0]  cwnd, cwnd_next;
  logic [7:0]  thresh, thresh_next;
  logic        mode_bit, mode_bit_next;
  logic        grew, grew_next;
  logic [31:0] last_ack_seq, last_ack_seq_next;
  logic        last_ack_valid, last_ack_valid_next;
  logic [1:0]  dup_count, dup_count_next;
  logic [15:0] loss_timer, loss_timer_next;
  logic [15:0] period_timer, period_timer_next;

  function automatic logic [7:0] grow(input logic [7:0] c);
    grow = (c < MAX_W) ? c + 8'd1 : c;
  endfunction

  function automatic logic [7:0] half_floor2(input logic [7:0] c);
    logic [7:0] h;
    h = {1'b0, c[7:1]};
    half_floor2 = (h < 8'd2) ? 8'd2 : h;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    sat_inc = (x != 16'hFFFF) ? x + 16'd1 : x;
  endfunction

  op_t         op;
  logic [7:0]  w_init;
  logic [7:0]  c1, c2;
  logic        m1;
  logic        is_dup;
  logic [1:0]  dup_inc;
  logic [15:0] l1, p1;
  logic        fast, tmo;
  logic [31:0] rseq;

  always_comb begin
    op      = op_t'(opcode);
    w_init  = cfg.init_window;
    if (w_init == 8'd0) begin
      w_init = 8'd1;
    end
    if (w_init > MAX_W) begin
      w_init = MAX_W;
    end
    c1      = mode_bit ? cwnd : grow(cwnd);
    m1      = mode_bit | (c1 >= thresh);
    c2      = (m1 && !grew) ? grow(c1) : c1;
    is_dup  = last_ack_valid && (ack_number == last_ack_seq);
    dup_inc = dup_count + 2'd1;
    l1      = sat_inc(loss_timer);
    p1      = sat_inc(period_timer);

    active_next         = active;
    cwnd_next           = cwnd;
    thresh_next         = thresh;
    mode_bit_next       = mode_bit;
    grew_next           = grew;
    last_ack_seq_next   = last_ack_seq;
    last_ack_valid_next = last_ack_valid;
    dup_count_next      = dup_count;
    loss_timer_next     = loss_timer;
    period_timer_next   = period_timer;
    fast                = 1'b0;
    tmo                 = 1'b0;
    rseq                = 32'd0;

    case (op)
      OP_START: begin
        active_next         = 1'b1;
        cwnd_next           = w_init;
        thresh_next         = cfg.init_ssthresh;
        mode_bit_next       = 1'b0;
        grew_next           = 1'b0;
        last_ack_seq_next   = 32'd0;
        last_ack_valid_next = 1'b0;
        dup_count_next      = 2'd0;
        loss_timer_next     = 16'd0;
        period_timer_next   = 16'd0;
      end
      OP_STOP: begin
        active_next = 1'b0;
      end
      OP_ACK: begin
        if (active) begin
          cwnd_next     = c2;
          mode_bit_next = m1;
          grew_next     = 1'b1;
          if (is_dup) begin
            if (dup_inc == DUP_L) begin
              thresh_next     = half_floor2(c2);
              cwnd_next       = 8'd1;
              mode_bit_next   = 1'b0;
              loss_timer_next = 16'd0;
              dup_count_next  = 2'd0;
              fast            = 1'b1;
              rseq            = ack_number + 32'd1;
            end else begin
              dup_count_next = dup_inc;
            end
          end else begin
            last_ack_seq_next   = ack_number;
            last_ack_valid_next = 1'b1;
            dup_count_next      = 2'd0;
            loss_timer_next     = 16'd0;
          end
        end
      end
      OP_TICK: begin
        if (active) begin
          loss_timer_next = l1;
          if (l1 >= cfg.timeout_ticks) begin
            thresh_next     = half_floor2(cwnd);
            cwnd_next       = 8'd1;
            mode_bit_next   = 1'b0;
            loss_timer_next = 16'd0;
            tmo             = 1'b1;
          end
          period_timer_next = p1;
          if (p1 >= cfg.rtt_ticks) begin
            grew_next         = 1'b0;
            period_timer_next = 16'd0;
          end
        end
      end
      default: begin
        active_next = active;
      end
    endcase

    result.window_now     = cwnd_next;
    result.threshold_now  = thresh_next;
    result.avoid_mode     = mode_bit_next;
    result.fast_resend    = fast;
    result.resend_seq     = rseq;
    result.timeout_resend = tmo;
    result.session_active = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      cwnd           <= 8'd1;
      thresh         <= 8'd64;
      mode_bit       <= 1'b0;
      grew           <= 1'b0;
      last_ack_seq   <= 32'd0;
      last_ack_valid <= 1'b0;
      dup_count      <= 2'd0;
      loss_timer     <= 16'd0;
      period_timer   <= 16'd0;
    end else if (accept) begin
      active         <= active_next;
      cwnd           <= cwnd_next;
      thresh         <= thresh_next;
      mode_bit       <= mode_bit_next;
      grew           <= grew_next;
      last_ack_seq   <= last_ack_seq_next;
      last_ack_valid <= last_ack_valid_next;
      dup_count      <= dup_count_next;
      loss_timer     <= loss_timer_next;
      period_timer   <= period_timer_next;
    end
  end

  assign stat.active = active;
  assign stat.cwnd   = cwnd;

endmodule

`default_nettype wire

### src/cwc_outq.sv
// cwc_outq: two-entry result buffer, output register plus skid register
// lets the event side keep going while a result waits on a stalled consumer
// depends on cwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module cwc_outq import cwc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    can_load;

  assign can_load = !out_valid || !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (can_load) begin
      out_valid  <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (!can_load && push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

### src/congestion_window_controller.sv
// congestion_window_controller: sender-side congestion window, slow start and
// avoidance, fast retransmit on duplicate acks, loss and round-trip timers
// a taken event's result is registered in the output register, or in the skid register while res_stall holds the output
// throughput: one event per cycle while evt_stall is low
// reset: synchronous; session inactive, window 1, threshold 64, registers at defaults
// depends on cwc_pkg, cwc_engine, cwc_outq
`timescale 1ns / 1ps
`default_nettype none

module congestion_window_controller import cwc_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int DUP_LIMIT  = DUP_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  evt_valid,
  output logic                       evt_stall,
  input  wire logic [1:0]            opcode,
  input  wire logic [31:0]           ack_number,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output logic [7:0]                 window_now,
  output logic [7:0]                 threshold_now,
  output logic                       avoid_mode,
  output logic                       fast_resend,
  output logic [31:0]                resend_seq,
  output logic                       timeout_resend,
  output logic                       session_active
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     evt_accept;
  logic     q_full;
  result_t  eng_result;
  result_t  res_data;
  status_t  stat;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_window   <= INIT_WINDOW_RST;
      cfg.init_ssthresh <= INIT_SSTHRESH_RST;
      cfg.rtt_ticks     <= RTT_TICKS_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_INIT_WINDOW:   cfg.init_window   <= pwdata[7:0];
        REG_INIT_SSTHRESH: cfg.init_ssthresh <= pwdata[7:0];
        REG_RTT_TICKS:     cfg.rtt_ticks     <= pwdata[15:0];
        REG_TIMEOUT_TICKS: cfg.timeout_ticks <= pwdata[15:0];
        default: begin
          cfg.init_window <= cfg.init_window;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INIT_WINDOW:   prdata = {24'd0, cfg.init_window};
      REG_INIT_SSTHRESH: prdata = {24'd0, cfg.init_ssthresh};
      REG_RTT_TICKS:     prdata = {16'd0, cfg.rtt_ticks};
      REG_TIMEOUT_TICKS: prdata = {16'd0, cfg.timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  assign evt_stall  = q_full;
  assign evt_accept = evt_valid && !evt_stall;

  cwc_engine #(
    .MAX_WINDOW (MAX_WINDOW),
    .DUP_LIMIT  (DUP_LIMIT)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .accept     (evt_accept),
    .opcode     (opcode),
    .ack_number (ack_number),
    .cfg        (cfg),
    .result     (eng_result),
    .stat       (stat)
  );

  cwc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_accept),
    .push_data (eng_result),
    .full      (q_full),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_data  (res_data)
  );

  assign window_now     = res_data.window_now;
  assign threshold_now  = res_data.threshold_now;
  assign avoid_mode     = res_data.avoid_mode;
  assign fast_resend    = res_data.fast_resend;
  assign resend_seq     = res_data.resend_seq;
  assign timeout_resend = res_data.timeout_resend;
  assign session_active = res_data.session_active;

  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    q_full |-> res_valid)
    else $error("skid entry held with no result on the output");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    (stat.cwnd != 8'd0) && (stat.cwnd <= 8'(MAX_WINDOW)))
    else $error("window outside 1..max");

  a_start_activates: assert property (@(posedge clk) disable iff (rst)
    (evt_accept && (opcode == OP_START)) |=> stat.active)
    else $error("session not active after start");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    evt_accept |=> res_valid)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
